// File: hdl/test_pattern_counter_overlay_defines.svh
// Assertion macros shared by the checker of the test pattern block.
`ifndef TEST_PATTERN_COUNTER_OVERLAY_DEFINES_SVH
`define TEST_PATTERN_COUNTER_OVERLAY_DEFINES_SVH

// Same-cycle implication.
`define TPCO_ASSERT_IMPLY(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("same-cycle implication failed");

// Next-cycle implication.
`define TPCO_ASSERT_NEXT(name, clk, rst, lhs, rhs) \
   name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle implication failed");

`endif

// File: hdl/tpco_pkg.sv
package tpco_pkg;

   localparam int POS_W      = 14;
   localparam int DIM_W      = 15;
   localparam int GAIN_W     = 12;
   localparam int CNT_W      = 27;
   localparam int BCD_MAX_W  = 40;
   localparam int DIV_W      = 22;
   localparam int WITHIN_W   = 4;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam int RED_SPAN    = 200;
   localparam int GREEN_SPAN  = 180;
   localparam int BLUE_BASE   = 80;
   localparam int BOX_X0      = 2;
   localparam int BOX_X1      = 80;
   localparam int BOX_Y0      = 2;
   localparam int BOX_Y1      = 20;
   localparam int DIGIT_X0    = 4;
   localparam int DIGIT_Y0    = 4;
   localparam int DIGIT_Y1    = 18;
   localparam int DIGIT_LAST  = 11;
   localparam int GLYPH_SPAN  = 10;
   localparam int GAIN_MIN    = 13;
   localparam int GAIN_MAX    = 2048;
   localparam int SAT_LIMIT   = 65280;
   localparam int ROUND_HALF  = 128;
   localparam int RESET_W     = 640;
   localparam int RESET_H     = 480;
   localparam int RESET_GAIN  = 256;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_GAIN   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [12:0]       width;
      logic [12:0]       height;
      logic [GAIN_W-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]     x;
      logic [POS_W-1:0]     y;
      logic [DIM_W-1:0]     width;
      logic [DIM_W-1:0]     height;
      logic [GAIN_W-1:0]    gain;
      logic [CNT_W-1:0]     frame;
      logic [BCD_MAX_W-1:0] bcd;
      logic [POS_W-1:0]     digit;
      logic [WITHIN_W-1:0]  slot_pos;
      logic                 line_last;
      logic                 frame_last;
   } job_type;

   localparam logic [4:0] GLYPHS [10][7] = '{
      '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
      '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
      '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
      '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
      '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
      '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
      '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
   };

   function automatic logic [4:0] glyph_row(input logic [3:0] d, input logic [2:0] r);
      logic [4:0] bits;
      bits = 5'd0;
      if (d < 4'd10 && r < 3'd7) begin
         bits = GLYPHS[d][r];
      end
      return bits;
   endfunction

endpackage

// File: hdl/tpco_queue.sv
module tpco_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: hdl/tpco_front.sv
module tpco_front #(
   parameter int MAX_DIMENSION = 4096,
   parameter int COUNT_DIGITS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  tpco_pkg::cfg_type cfg,
   input  logic              push,
   input  logic              start_over,
   input  logic              q_full,
   output logic              q_push,
   output tpco_pkg::job_type job
);
   import tpco_pkg::*;

   localparam int BCD_W = 4 * COUNT_DIGITS;

   logic [POS_W-1:0]    col_ff, col_in, row_ff, row_in, digit_ff, digit_in;
   logic [WITHIN_W-1:0] within_ff, within_in;
   logic [CNT_W-1:0]    frame_ff, frame_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [DIM_W-1:0]    lat_w_ff, lat_w_in, lat_h_ff, lat_h_in;
   logic [GAIN_W-1:0]   lat_gain_ff, lat_gain_in;

   logic [POS_W-1:0]  x, y;
   logic [CNT_W-1:0]  f;
   logic [BCD_W-1:0]  bcd;
   logic [DIM_W-1:0]  w_clamp, h_clamp;
   logic [GAIN_W-1:0] g_clamp;
   logic              first, ll, fl, accept;

   assign accept = push && !q_full;
   assign q_push = accept;

   always_comb begin
      logic       carry;
      logic [3:0] d;
      logic [POS_W-1:0] xn;
      carry = 1'b0;
      d     = 4'd0;
      // zero position and counter first on a restart
      x     = start_over ? '0 : col_ff;
      y     = start_over ? '0 : row_ff;
      f     = start_over ? '0 : frame_ff;
      bcd   = start_over ? '0 : bcd_ff;
      first = (x == '0) && (y == '0);

      w_clamp = {2'b00, cfg.width};
      if (cfg.width == '0) w_clamp = DIM_W'(1);
      else if ({2'b00, cfg.width} > DIM_W'(MAX_DIMENSION)) w_clamp = DIM_W'(MAX_DIMENSION);
      h_clamp = {2'b00, cfg.height};
      if (cfg.height == '0) h_clamp = DIM_W'(1);
      else if ({2'b00, cfg.height} > DIM_W'(MAX_DIMENSION)) h_clamp = DIM_W'(MAX_DIMENSION);
      g_clamp = cfg.gain;
      if (cfg.gain < GAIN_W'(GAIN_MIN)) g_clamp = GAIN_W'(GAIN_MIN);
      else if (cfg.gain > GAIN_W'(GAIN_MAX)) g_clamp = GAIN_W'(GAIN_MAX);

      lat_w_in    = first ? w_clamp : lat_w_ff;
      lat_h_in    = first ? h_clamp : lat_h_ff;
      lat_gain_in = first ? g_clamp : lat_gain_ff;

      ll = ({1'b0, x} + 1'b1) >= lat_w_in;
      fl = ll && (({1'b0, y} + 1'b1) >= lat_h_in);

      col_in    = x;
      row_in    = y;
      frame_in  = f;
      bcd_in    = bcd;
      digit_in  = digit_ff;
      within_in = within_ff;
      xn        = x + 1'b1;
      if (ll) begin
         col_in = '0;
         if (fl) begin
            row_in   = '0;
            frame_in = f + 1'b1;
            carry    = 1'b1;
            for (int i = 0; i < COUNT_DIGITS; i++) begin
               d = bcd[4*i +: 4];
               if (carry) begin
                  if (d >= 4'd9) begin
                     bcd_in[4*i +: 4] = 4'd0;
                  end else begin
                     bcd_in[4*i +: 4] = d + 1'b1;
                     carry = 1'b0;
                  end
               end
            end
            if (carry) begin
               frame_in = '0;
               bcd_in   = '0;
            end
         end else begin
            row_in = y + 1'b1;
         end
      end else begin
         col_in = xn;
         // track digit slot and offset inside it for the overlay
         if (xn == POS_W'(DIGIT_X0)) begin
            digit_in  = '0;
            within_in = '0;
         end else if (within_ff == WITHIN_W'(DIGIT_LAST)) begin
            digit_in  = digit_ff + 1'b1;
            within_in = '0;
         end else begin
            within_in = within_ff + 1'b1;
         end
      end

      job.x          = x;
      job.y          = y;
      job.width      = lat_w_in;
      job.height     = lat_h_in;
      job.gain       = lat_gain_in;
      job.frame      = f;
      job.bcd        = BCD_MAX_W'(bcd);
      job.digit      = digit_ff;
      job.slot_pos   = within_ff;
      job.line_last  = ll;
      job.frame_last = fl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         frame_ff    <= '0;
         bcd_ff      <= '0;
         digit_ff    <= '0;
         within_ff   <= '0;
         lat_w_ff    <= DIM_W'(RESET_W);
         lat_h_ff    <= DIM_W'(RESET_H);
         lat_gain_ff <= GAIN_W'(RESET_GAIN);
      end else if (accept) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         frame_ff    <= frame_in;
         bcd_ff      <= bcd_in;
         digit_ff    <= digit_in;
         within_ff   <= within_in;
         lat_w_ff    <= lat_w_in;
         lat_h_ff    <= lat_h_in;
         lat_gain_ff <= lat_gain_in;
      end
   end
endmodule

// File: hdl/tpco_back.sv
module tpco_back #(
   parameter int COUNT_DIGITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  tpco_pkg::job_type job_in,
   input  logic              job_valid,
   output logic              job_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_line_last,
   output logic              rsp_frame_last,
   output logic [26:0]       rsp_frame_index
);
   import tpco_pkg::*;

   localparam int STEP_W = $clog2(DIV_W);
   localparam int ND_W   = $clog2(COUNT_DIGITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_COLOR = 4'b0100,
      ST_GAIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   job_type   job_ff;
   logic [DIV_W-1:0]  dvd_r_ff, dvd_g_ff;
   logic [DIM_W-1:0]  rem_r_ff, rem_g_ff, rem_r_in, rem_g_in;
   logic [7:0]        q_r_ff, q_g_ff;
   logic              q_r_bit, q_g_bit;
   logic [STEP_W-1:0] step_ff;
   logic [7:0]        r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic [7:0]        red_in, green_in, blue_in;
   logic              out_valid_ff, out_load;

   // one restoring step for both quotients
   always_comb begin
      logic [DIM_W:0] rs_r, rs_g;
      rs_r    = {rem_r_ff, dvd_r_ff[DIV_W-1]};
      rs_g    = {rem_g_ff, dvd_g_ff[DIV_W-1]};
      q_r_bit = rs_r >= {1'b0, job_ff.width};
      q_g_bit = rs_g >= {1'b0, job_ff.height};
      rem_r_in = q_r_bit ? DIM_W'(rs_r - {1'b0, job_ff.width})  : DIM_W'(rs_r);
      rem_g_in = q_g_bit ? DIM_W'(rs_g - {1'b0, job_ff.height}) : DIM_W'(rs_g);
   end

   // background, box and digit overlay
   always_comb begin
      logic [ND_W-1:0]  nd;
      logic [3:0]       d;
      logic [4:0]       gl;
      logic [2:0]       col;
      logic [POS_W-1:0] yo;
      logic [7:0]       f8;
      logic             dot;
      f8 = job_ff.frame[7:0];
      nd = ND_W'(1);
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (job_ff.bcd[4*i +: 4] != 4'd0) nd = ND_W'(i + 1);
      end
      d = 4'd0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if ((POS_W+1)'(job_ff.digit) + (POS_W+1)'(i + 1) == (POS_W+1)'(nd)) begin
            d = job_ff.bcd[4*i +: 4];
         end
      end
      yo  = job_ff.y - POS_W'(DIGIT_Y0);
      col = job_ff.slot_pos[3:1];
      gl  = glyph_row(d, yo[3:1]);
      dot = (job_ff.y >= POS_W'(DIGIT_Y0)) && (job_ff.y < POS_W'(DIGIT_Y1))
         && (job_ff.x >= POS_W'(DIGIT_X0))
         && ((POS_W+1)'(job_ff.digit) < (POS_W+1)'(nd))
         && (job_ff.slot_pos < WITHIN_W'(GLYPH_SPAN))
         && gl[3'd4 - col];
      r_in = q_r_ff + {f8[6:0], 1'b0};
      g_in = q_g_ff + f8 + {f8[6:0], 1'b0};
      b_in = 8'(BLUE_BASE) + {2'b00, f8[5:0]};
      if (job_ff.x >= POS_W'(BOX_X0) && job_ff.x < POS_W'(BOX_X1)
          && job_ff.y >= POS_W'(BOX_Y0) && job_ff.y < POS_W'(BOX_Y1)) begin
         r_in = '0;
         g_in = '0;
         b_in = '0;
      end
      if (dot) begin
         r_in = 8'hFF;
         g_in = 8'hFF;
         b_in = 8'hFF;
      end
   end

   function automatic logic [7:0] gain_apply(input logic [7:0] v, input logic [GAIN_W-1:0] k);
      logic [19:0] p;
      logic [19:0] pr;
      p  = 20'(v) * 20'(k);
      pr = p + 20'(ROUND_HALF);
      return (p >= 20'(SAT_LIMIT)) ? 8'hFF : pr[15:8];
   endfunction

   assign red_in   = gain_apply(r_ff, job_ff.gain);
   assign green_in = gain_apply(g_ff, job_ff.gain);
   assign blue_in  = gain_apply(b_ff, job_ff.gain);

   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign out_load  = (state_ff == ST_GAIN) && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_DIV;
         ST_DIV:   if (step_ff == '0) state_in = ST_COLOR;
         ST_COLOR: state_in = ST_GAIN;
         ST_GAIN:  if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff   <= job_in;
         dvd_r_ff <= DIV_W'(job_in.x) * DIV_W'(RED_SPAN);
         dvd_g_ff <= DIV_W'(job_in.y) * DIV_W'(GREEN_SPAN);
         rem_r_ff <= '0;
         rem_g_ff <= '0;
         q_r_ff   <= '0;
         q_g_ff   <= '0;
         step_ff  <= STEP_W'(DIV_W - 1);
      end else if (state_ff == ST_DIV) begin
         dvd_r_ff <= {dvd_r_ff[DIV_W-2:0], 1'b0};
         dvd_g_ff <= {dvd_g_ff[DIV_W-2:0], 1'b0};
         rem_r_ff <= rem_r_in;
         rem_g_ff <= rem_g_in;
         q_r_ff   <= {q_r_ff[6:0], q_r_bit};
         q_g_ff   <= {q_g_ff[6:0], q_g_bit};
         step_ff  <= step_ff - 1'b1;
      end
      if (state_ff == ST_COLOR) begin
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
      end
      if (out_load) begin
         rsp_red         <= red_in;
         rsp_green       <= green_in;
         rsp_blue        <= blue_in;
         rsp_line_last   <= job_ff.line_last;
         rsp_frame_last  <= job_ff.frame_last;
         rsp_frame_index <= job_ff.frame;
      end
   end
endmodule

// File: hdl/test_pattern_counter_overlay.sv
// Pixels wait in a two-entry queue; the back end renders one pixel at a time, its pace
//   set by the 22-step restoring division for the red and green gradients and by
//   the result register in the back end, which holds a pixel until it is popped.
// Reset (synchronous, active high): position and frame counter at zero, registers
//   at 640 x 480 with unity gain, the queue and the result register empty.
module test_pattern_counter_overlay #(
   parameter int MAX_DIMENSION = 4096,
   parameter int COUNT_DIGITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_start_over,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_line_last,
   output logic        rsp_frame_last,
   output logic [26:0] rsp_frame_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tpco_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpco_pkg::CSR_DATA_W-1:0] csr_data
);
   import tpco_pkg::*;

   cfg_type cfg_ff;
   job_type front_job, back_job;
   logic    q_full, q_empty, q_push, q_pop;

   // Registers take a write in any cycle; the front end samples them at frame start.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= 13'(RESET_W);
         cfg_ff.height <= 13'(RESET_H);
         cfg_ff.gain   <= GAIN_W'(RESET_GAIN);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WIDTH:  cfg_ff.width  <= csr_data;
            REG_HEIGHT: cfg_ff.height <= csr_data;
            REG_GAIN:   cfg_ff.gain   <= csr_data[GAIN_W-1:0];
            default:    ;  // drop writes to unused indexes
         endcase
      end
   end

   // Front end: raster position, frame counter, config snapshot, overlay slot.
   tpco_front #(
      .MAX_DIMENSION (MAX_DIMENSION),
      .COUNT_DIGITS  (COUNT_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (req_push),
      .start_over (req_start_over),
      .q_full     (q_full),
      .q_push     (q_push),
      .job        (front_job)
   );

   // Two-entry queue decouples pixel classification from rendering.
   assign req_full = q_full;

   tpco_queue #(
      .WIDTH ($bits(job_type)),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (back_job),
      .empty     (q_empty)
   );

   // Back end: gradient divide, box and glyph overlay, gain, result register.
   tpco_back #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_in          (back_job),
      .job_valid       (!q_empty),
      .job_pop         (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_line_last   (rsp_line_last),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_frame_index (rsp_frame_index)
   );
endmodule

// File: hdl/tpco_checker.sv
`include "test_pattern_counter_overlay_defines.svh"

module tpco_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        req_start_over,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic        rsp_line_last,
   input logic        rsp_frame_last,
   input logic [26:0] rsp_frame_index,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [12:0] csr_data
);
   // a frame ends only at the end of a line
   `TPCO_ASSERT_IMPLY(a_frame_ends_line, clock, reset, !rsp_empty && rsp_frame_last, rsp_line_last)
   // hold a waiting pixel until taken
   `TPCO_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_red) && $stable(rsp_frame_index))
   // reset leaves no result behind
   `TPCO_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)
   // register writes never stall
   `TPCO_ASSERT_IMPLY(a_csr_ready, clock, reset, csr_valid, csr_ready)
endmodule

bind test_pattern_counter_overlay tpco_checker u_tpco_checker (.*);
